### rtl/cosine_nearest_match_defines.svh
// Assertion macros shared by the cosine match RTL.
`ifndef COSINE_NEAREST_MATCH_DEFINES_SVH
`define COSINE_NEAREST_MATCH_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CNM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CNM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/cnm_pkg.sv
// Package with sizes, command codes and types for the cosine match block.
`timescale 1ns / 1ps
`default_nettype none
package cnm_pkg;
    localparam int MaxRecords = 256;
    localparam int MaxDim = 512;
    localparam int RecW = $clog2(MaxRecords);
    localparam int CntW = $clog2(MaxRecords + 1);
    localparam int DimW = $clog2(MaxDim);
    localparam int PosW = $clog2(MaxDim + 1);
    localparam int AddrW = RecW + DimW;
    // Accumulator widths: a sum of MaxDim products of two 16-bit values.
    localparam int DotW = 31 + PosW + 1;
    localparam int NormW = 30 + PosW + 1;
    localparam int RootW = (NormW + 1) / 2;
    localparam int DenW = 2 * RootW;
    localparam int NumW = DotW + 15;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;
endpackage
`default_nettype wire

### rtl/cnm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cnm_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [cnm_pkg::NumW-1:0]    numer,
    input  wire logic [cnm_pkg::DenW-1:0]    denom,
    output logic                             done,
    output logic [cnm_pkg::NumW-1:0]         quot
);
    localparam int BitW = $clog2(cnm_pkg::NumW + 1);
    logic [cnm_pkg::NumW-1:0] q_reg, q_next;
    logic [cnm_pkg::DenW-1:0] r_reg, r_next;
    logic [cnm_pkg::DenW-1:0] d_reg;
    logic [BitW-1:0]          n_reg, n_next;
    logic                     busy_reg, busy_next, done_reg, done_next;
    logic [cnm_pkg::DenW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[cnm_pkg::NumW-1]};
        if (start) begin
            q_next = numer;
            r_next = '0;
            n_next = BitW'(cnm_pkg::NumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = cnm_pkg::DenW'(trial - {1'b0, d_reg});
                q_next = {q_reg[cnm_pkg::NumW-2:0], 1'b1};
            end else begin
                r_next = trial[cnm_pkg::DenW-1:0];
                q_next = {q_reg[cnm_pkg::NumW-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == BitW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        n_reg <= n_next;
        if (start) d_reg <= denom;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

### rtl/cosine_nearest_match.sv
// Top level of the cosine-similarity nearest-record search.
// Add and query words are taken one per cycle while s_ready is high and written
// to the feature and query memories. A closing query word starts a search: the
// sequencer walks every stored record with three multiply-accumulate units, one
// element a cycle with a registered memory read, then takes two bit-per-cycle
// square roots of the norms, one multiply, and a bit-per-cycle divide. A record
// with a zero norm skips the divide, and a record whose length does not match
// the query skips the accumulation and scores zero. s_ready stays low during a
// search and while the result word waits for m_ready. The stores need no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "cosine_nearest_match_defines.svh"
module cosine_nearest_match (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic signed [15:0] s_element_value,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [7:0]       m_best_index,
    output logic signed [15:0] m_best_score,
    output logic             m_match,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic signed [15:0] cfg_data
);
    localparam int RecW = cnm_pkg::RecW;
    localparam int CntW = cnm_pkg::CntW;
    localparam int DimW = cnm_pkg::DimW;
    localparam int PosW = cnm_pkg::PosW;
    localparam int NormW = cnm_pkg::NormW;
    localparam int RootW = cnm_pkg::RootW;
    localparam int SvW = 2 * RootW;
    localparam int SqW = $clog2(RootW + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REC, ST_RD, ST_MAC, ST_MACL, ST_SQA, ST_SQB, ST_MUL,
        ST_DIV, ST_WAIT, ST_CMP, ST_OUT
    } state_t;

    logic signed [15:0] feat_mem [cnm_pkg::MaxRecords * cnm_pkg::MaxDim];
    logic [PosW-1:0]    len_mem [cnm_pkg::MaxRecords];
    logic signed [15:0] qry_mem [cnm_pkg::MaxDim];

    state_t state_reg;
    logic [CntW-1:0] count_reg;
    logic [PosW-1:0] pos_reg, qlen_reg, idx_reg;
    logic [RecW:0]   slot_reg;
    logic signed [15:0] thr_reg;
    logic signed [15:0] fa_reg, qb_reg;
    logic signed [15:0] best_reg;
    logic [RecW-1:0] best_slot_reg;
    logic [PosW-1:0] rlen_reg;
    logic signed [cnm_pkg::DotW-1:0] dot_reg;
    logic [NormW-1:0] na_reg, nb_reg;
    logic [SvW-1:0]   sv_reg;
    logic [RootW-1:0] root_reg, ra_reg;
    logic [RootW-1:0] rem_reg;
    logic [SqW-1:0]   sqn_reg;
    logic [cnm_pkg::DenW-1:0] den_reg;
    logic div_start_reg, div_done;
    logic [cnm_pkg::NumW-1:0] quot;
    logic [cnm_pkg::NumW-1:0] numer;
    logic out_valid_reg, o_found_reg, o_match_reg;
    logic [7:0] o_idx_reg;
    logic signed [15:0] o_score_reg;

    logic s_fire;
    logic [RootW+1:0] sq_trial;
    logic sq_take;
    logic [RootW-1:0] root_step;
    logic signed [31:0] prod_ab;
    logic signed [31:0] prod_aa, prod_bb;
    logic signed [16:0] score;
    logic dot_neg;
    logic [cnm_pkg::DotW-1:0] mag;

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign dot_neg = dot_reg[cnm_pkg::DotW-1];
    assign mag = dot_neg ? cnm_pkg::DotW'(-dot_reg) : cnm_pkg::DotW'(dot_reg);
    assign numer = {mag, 15'd0};
    assign prod_ab = fa_reg * qb_reg;
    assign prod_aa = fa_reg * fa_reg;
    assign prod_bb = qb_reg * qb_reg;
    assign sq_trial = {rem_reg, sv_reg[SvW-1 -: 2]};
    assign sq_take = sq_trial >= {root_reg, 2'b01};
    assign root_step = {root_reg[RootW-2:0], sq_take};

    always_comb begin
        if (dot_neg)
            score = (quot >= cnm_pkg::NumW'(32768)) ? -17'sd32768 : -$signed({1'b0, quot[15:0]});
        else
            score = (quot >= cnm_pkg::NumW'(32767)) ? 17'sd32767 : $signed({1'b0, quot[15:0]});
    end

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (s_fire && pos_reg < PosW'(cnm_pkg::MaxDim)) begin
            if (s_command == cnm_pkg::CMD_ADD && count_reg < CntW'(cnm_pkg::MaxRecords))
                feat_mem[{count_reg[RecW-1:0], pos_reg[DimW-1:0]}] <= s_element_value;
            if (s_command == cnm_pkg::CMD_QUERY)
                qry_mem[pos_reg[DimW-1:0]] <= s_element_value;
        end
        if (s_fire && s_last && s_command == cnm_pkg::CMD_ADD
            && count_reg < CntW'(cnm_pkg::MaxRecords))
            len_mem[count_reg[RecW-1:0]] <= (pos_reg < PosW'(cnm_pkg::MaxDim))
                ? pos_reg + 1'b1 : pos_reg;
        fa_reg <= feat_mem[{slot_reg[RecW-1:0], idx_reg[DimW-1:0]}];
        qb_reg <= qry_mem[idx_reg[DimW-1:0]];
        rlen_reg <= len_mem[slot_reg[RecW-1:0]];
    end

    cnm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .numer(numer), .denom(den_reg), .done(div_done), .quot(quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pos_reg <= '0;
            thr_reg <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid) thr_reg <= cfg_data;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg) inside
                ST_IDLE: begin
                    if (s_fire) begin
                        unique case (s_command) inside
                            cnm_pkg::CMD_CLEAR: begin
                                count_reg <= '0;
                                pos_reg <= '0;
                            end
                            cnm_pkg::CMD_ADD, cnm_pkg::CMD_QUERY: begin
                                if (s_last) begin
                                    pos_reg <= '0;
                                    if (s_command == cnm_pkg::CMD_ADD) begin
                                        if (count_reg < CntW'(cnm_pkg::MaxRecords))
                                            count_reg <= count_reg + 1'b1;
                                    end else begin
                                        qlen_reg <= (pos_reg < PosW'(cnm_pkg::MaxDim))
                                            ? pos_reg + 1'b1 : pos_reg;
                                        slot_reg <= '0;
                                        best_reg <= -16'sd32768;
                                        best_slot_reg <= '0;
                                        state_reg <= ST_REC;
                                    end
                                end else if (pos_reg < PosW'(cnm_pkg::MaxDim)) begin
                                    pos_reg <= pos_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_REC: begin
                    if (slot_reg == (RecW+1)'(count_reg)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        idx_reg <= '0;
                        dot_reg <= '0;
                        na_reg <= '0;
                        nb_reg <= '0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    // Length and first element reads are issued here and registered for ST_MAC.
                    if (qlen_reg == '0) begin
                        state_reg <= ST_MACL;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (rlen_reg != qlen_reg) begin
                        // Mismatched length scores zero.
                        if (best_reg < 16'sd0) begin
                            best_reg <= '0;
                            best_slot_reg <= slot_reg[RecW-1:0];
                        end
                        slot_reg <= slot_reg + 1'b1;
                        state_reg <= ST_REC;
                    end else begin
                        dot_reg <= dot_reg + cnm_pkg::DotW'(prod_ab);
                        na_reg <= na_reg + NormW'(prod_aa);
                        nb_reg <= nb_reg + NormW'(prod_bb);
                        if (idx_reg == qlen_reg) begin
                            sv_reg <= SvW'(na_reg + NormW'(prod_aa));
                            root_reg <= '0;
                            rem_reg <= '0;
                            sqn_reg <= SqW'(RootW);
                            state_reg <= ST_SQA;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_MACL: begin
                    // Empty query: reached when the query length is zero; the record scores zero either way.
                    if (rlen_reg != qlen_reg && best_reg < 16'sd0) begin
                        best_reg <= '0;
                        best_slot_reg <= slot_reg[RecW-1:0];
                    end else if (rlen_reg == qlen_reg && best_reg < 16'sd0) begin
                        best_reg <= '0;
                        best_slot_reg <= slot_reg[RecW-1:0];
                    end
                    slot_reg <= slot_reg + 1'b1;
                    state_reg <= ST_REC;
                end
                ST_SQA, ST_SQB: begin
                    // One root bit a cycle, digit-by-digit.
                    if (sqn_reg == SqW'(1) && state_reg == ST_SQA) begin
                        ra_reg <= root_step;
                        sv_reg <= SvW'(nb_reg);
                        root_reg <= '0;
                        rem_reg <= '0;
                        sqn_reg <= SqW'(RootW);
                        state_reg <= ST_SQB;
                    end else begin
                        sv_reg <= {sv_reg[SvW-3:0], 2'b00};
                        root_reg <= root_step;
                        rem_reg <= sq_take ? RootW'(sq_trial - {root_reg, 2'b01})
                            : sq_trial[RootW-1:0];
                        sqn_reg <= sqn_reg - 1'b1;
                        if (sqn_reg == SqW'(1)) state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    den_reg <= ra_reg * root_reg;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (den_reg == '0) begin
                        if (best_reg < 16'sd0) begin
                            best_reg <= '0;
                            best_slot_reg <= slot_reg[RecW-1:0];
                        end
                        slot_reg <= slot_reg + 1'b1;
                        state_reg <= ST_REC;
                    end else begin
                        div_start_reg <= 1'b1;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (div_done) state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (score > 17'(best_reg)) begin
                        best_reg <= score[15:0];
                        best_slot_reg <= slot_reg[RecW-1:0];
                    end
                    slot_reg <= slot_reg + 1'b1;
                    state_reg <= ST_REC;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    o_found_reg <= count_reg != '0;
                    o_idx_reg <= 8'(best_slot_reg);
                    o_score_reg <= best_reg;
                    o_match_reg <= best_reg >= thr_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_found = o_found_reg;
    assign m_best_index = o_idx_reg;
    assign m_best_score = o_score_reg;
    assign m_match = o_match_reg;

    `CNM_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `CNM_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CNM_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CntW'(cnm_pkg::MaxRecords))
    `CNM_ASSERT_NEXT(a_div_done, aclk, aresetn, state_reg == ST_CMP, state_reg == ST_REC)
endmodule
`default_nettype wire
